FILE: rtl/stmsd_pkg.sv
package stmsd_pkg;

	localparam int SAMPLE_W            = 16;
	localparam int FRAC_W              = 8;
	localparam int VAR_SHIFT           = 2 * FRAC_W;
	localparam int MEAN_W              = 24;
	localparam int SD_W                = 24;
	localparam int CNT_OUT_W           = 5;
	localparam int TRIM_MIN_COUNT      = 3;
	localparam int DEFAULT_MAX_SAMPLES = 16;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       is_last;
	} in_item_t;

	typedef struct packed {
		logic signed [MEAN_W-1:0] trimmed_mean;
		logic                     trimmed_valid;
		logic [SD_W-1:0]          std_dev;
		logic [CNT_OUT_W-1:0]     sample_count;
		logic                     overflowed;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_ACC,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_MUL,
		ST_DEV,
		ST_VAR_GO,
		ST_VAR_WAIT,
		ST_SQRT_WAIT,
		ST_TRIM_GO,
		ST_TRIM_WAIT,
		ST_PUB
	} state_t;

	typedef enum logic [1:0] {
		DIV_MEAN,
		DIV_VAR,
		DIV_TRIM
	} div_sel_t;

	typedef struct packed {
		logic     accum;
		logic     div_start;
		div_sel_t div_sel;
		logic     cap_mean;
		logic     cap_prod;
		logic     cap_dev;
		logic     sqrt_start;
		logic     cap_sd;
		logic     cap_trim;
		logic     publish;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic sqrt_done;
		logic trim_ok;
	} status_t;

endpackage

FILE: rtl/stmsd_stream_if.sv
interface stmsd_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/sample_trimmed_mean_stddev_core.sv
// Trimmed mean and population standard deviation of a set of signed 16-bit
// samples. Samples stream in at one request per clock while the block is
// accumulating; only count, sum, sum of squares, minimum and maximum are kept,
// so no sample memory exists. The request marked is_last closes the set and
// yields one result: the olympic mean (sum less min and max over count-2) and
// the standard deviation about the truncated integer mean, both Q.8 and
// truncated. Fewer than three samples give trimmed_valid = 0 with a zero mean;
// samples past MAX_SAMPLES are dropped and reported in overflowed. Closing a
// set runs three passes through the shared one-bit-per-cycle divider (integer
// mean, variance, trimmed mean), one pass through the two-bits-per-cycle
// square root, and the product, deviation and publish steps. A set of fewer
// than three samples skips the trimmed-mean pass. The sample port is held off
// during that time, and longer if the previous result has not been taken; a
// finished result sits in the output register and the next set may begin
// accumulating before it is taken.
module sample_trimmed_mean_stddev_core #(
	parameter int MAX_SAMPLES = stmsd_pkg::DEFAULT_MAX_SAMPLES
) (
	input  logic            clk,
	input  logic            arst_n,
	stmsd_stream_if.sink    samples,
	stmsd_stream_if.source  results
);
	stmsd_pkg::cmd_t      cmd;
	stmsd_pkg::status_t   status;
	stmsd_pkg::in_item_t  item;
	stmsd_pkg::out_item_t result;

	assign item = samples.payload;

	// sequencer owns both handshakes
	stmsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_last   (item.is_last),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// accumulators, shared divider, root unit, output register
	stmsd_datapath #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.status (status),
		.item   (item),
		.result (result)
	);

	assign results.payload = result;
endmodule

FILE: rtl/stmsd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module stmsd_div #(
	parameter int DW = 51,
	parameter int VW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient,
	output logic [VW-1:0] remainder
);
	localparam int CNTW = $clog2(DW);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   dq_q;
	logic [VW-1:0]   rem_q;
	logic [VW-1:0]   dvs_q;

	logic [VW:0] trial;
	logic [VW:0] diff;
	logic        ge;

	assign trial = {rem_q, dq_q[DW-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
			dq_q  <= {dq_q[DW-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = dq_q;
	assign remainder = rem_q;
endmodule

FILE: rtl/stmsd_sqrt.sv
// Integer square root (floor), two radicand bits per cycle.
module stmsd_sqrt #(
	parameter int VW = 51
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VW-1:0]         operand,
	output logic                  done,
	output logic [(VW+1)/2-1:0]   root
);
	localparam int RW = (VW + 1) / 2;
	localparam int EW = 2 * RW;

	logic          busy_q;
	logic          done_q;
	logic [EW-1:0] v_q;
	logic [EW-1:0] root_q;
	logic [EW-1:0] bit_q;

	logic [EW-1:0] trial;
	logic          ge;

	assign trial = root_q + bit_q;
	assign ge    = v_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= EW'(operand);
			root_q <= '0;
			bit_q  <= {2'b01, {(EW-2){1'b0}}};
		end else if (busy_q) begin
			if (ge) begin
				v_q    <= v_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = root_q[RW-1:0];
endmodule

FILE: rtl/stmsd_datapath.sv
// Accumulators, result arithmetic and output register.
module stmsd_datapath #(
	parameter int MAX_SAMPLES = stmsd_pkg::DEFAULT_MAX_SAMPLES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  stmsd_pkg::cmd_t     cmd,
	output stmsd_pkg::status_t  status,
	input  stmsd_pkg::in_item_t item,
	output stmsd_pkg::out_item_t result
);
	localparam int XW   = stmsd_pkg::SAMPLE_W;
	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int SW   = XW + $clog2(MAX_SAMPLES);
	localparam int SQW  = 2 * XW - 1 + $clog2(MAX_SAMPLES);
	localparam int MW   = XW + 1;
	localparam int PW   = MW + SW + 1;
	localparam int DEVW = ((SQW + 1 > PW) ? SQW + 1 : PW) + 1;
	localparam int DVW  = SQW + stmsd_pkg::VAR_SHIFT;
	localparam int RW   = (DVW + 1) / 2;
	localparam int TW   = SW + 2;
	localparam int FW   = stmsd_pkg::FRAC_W;
	localparam int OW   = stmsd_pkg::MEAN_W;
	localparam int DW   = stmsd_pkg::SD_W;
	localparam int NW   = stmsd_pkg::CNT_OUT_W;

	// set accumulators
	logic [CW-1:0]          count_q;
	logic signed [SW-1:0]   sum_q;
	logic [SQW-1:0]         sq_q;
	logic signed [XW-1:0]   min_q;
	logic signed [XW-1:0]   max_q;
	logic                   dropped_q;

	// intermediate results
	logic signed [MW-1:0]   mean_q;
	logic signed [SW:0]     sr_q;
	logic signed [PW-1:0]   prod_q;
	logic [SQW-1:0]         dev_q;
	logic [OW-1:0]          trim_q;
	logic [DW-1:0]          sd_q;
	stmsd_pkg::out_item_t   out_q;

	logic signed [XW-1:0]   x;
	logic signed [2*XW-1:0] x_sq;
	logic                   full;
	logic                   trim_ok;

	logic [SW-1:0]          sum_mag;
	logic signed [TW-1:0]   t_w;
	logic [TW-1:0]          t_mag;
	logic signed [DEVW-1:0] dev_w;

	logic [DVW-1:0]         div_dividend;
	logic [CW-1:0]          div_divisor;
	logic                   div_done;
	logic [DVW-1:0]         div_quot;
	logic [CW-1:0]          div_rem;

	logic                   sqrt_done;
	logic [RW-1:0]          sqrt_root;

	logic signed [MW-1:0]   m_mag;
	logic signed [CW:0]     r_mag;
	logic signed [CW:0]     r_val;
	logic [OW-1:0]          q_trim;
	logic [CW+NW-1:0]       cnt_ext;

	assign x       = item.sample;
	assign x_sq    = x * x;
	assign full    = count_q == CW'(MAX_SAMPLES);
	assign trim_ok = count_q >= CW'(stmsd_pkg::TRIM_MIN_COUNT);

	assign sum_mag = sum_q[SW-1] ? (~sum_q + 1'b1) : sum_q;
	assign t_w     = {{2{sum_q[SW-1]}}, sum_q}
	               - {{(TW-XW){min_q[XW-1]}}, min_q}
	               - {{(TW-XW){max_q[XW-1]}}, max_q};
	assign t_mag   = t_w[TW-1] ? (~t_w + 1'b1) : t_w;
	// D = sum(x^2) - m*(S + r), r the remainder of S/n
	assign dev_w   = $signed({{(DEVW-SQW){1'b0}}, sq_q})
	               - {{(DEVW-PW){prod_q[PW-1]}}, prod_q};

	assign m_mag   = $signed(div_quot[MW-1:0]);
	assign r_mag   = $signed({1'b0, div_rem});
	assign r_val   = sum_q[SW-1] ? -r_mag : r_mag;
	assign q_trim  = div_quot[OW-1:0];
	assign cnt_ext = {{NW{1'b0}}, count_q};

	always_comb begin
		case (cmd.div_sel)
			stmsd_pkg::DIV_MEAN: begin
				div_dividend = {{(DVW-SW){1'b0}}, sum_mag};
				div_divisor  = count_q;
			end
			stmsd_pkg::DIV_VAR: begin
				div_dividend = {dev_q, {stmsd_pkg::VAR_SHIFT{1'b0}}};
				div_divisor  = count_q;
			end
			stmsd_pkg::DIV_TRIM: begin
				div_dividend = {{(DVW-TW-FW){1'b0}}, t_mag, {FW{1'b0}}};
				div_divisor  = count_q - CW'(2);
			end
			default: begin
				div_dividend = '0;
				div_divisor  = count_q;
			end
		endcase
	end

	stmsd_div #(
		.DW (DVW),
		.VW (CW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	stmsd_sqrt #(
		.VW (DVW)
	) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.sqrt_start),
		.operand (div_quot),
		.done    (sqrt_done),
		.root    (sqrt_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			sum_q     <= '0;
			sq_q      <= '0;
			dropped_q <= 1'b0;
		end else if (cmd.publish) begin
			count_q   <= '0;
			sum_q     <= '0;
			sq_q      <= '0;
			dropped_q <= 1'b0;
		end else if (cmd.accum) begin
			if (full) begin
				dropped_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_q + {{(SW-XW){x[XW-1]}}, x};
				sq_q    <= sq_q + {{(SQW-2*XW){1'b0}}, $unsigned(x_sq)};
			end
		end
	end

	// min/max loaded by the first sample of a set
	always_ff @(posedge clk) begin
		if (cmd.accum && !full) begin
			if (count_q == '0 || x < min_q) begin
				min_q <= x;
			end
			if (count_q == '0 || x > max_q) begin
				max_q <= x;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_mean) begin
			mean_q <= sum_q[SW-1] ? -m_mag : m_mag;
			sr_q   <= {sum_q[SW-1], sum_q} + {{(SW-CW){r_val[CW]}}, r_val};
		end
		if (cmd.cap_prod) begin
			prod_q <= mean_q * sr_q;
		end
		if (cmd.cap_dev) begin
			dev_q <= dev_w[DEVW-1] ? '0 : dev_w[SQW-1:0];
		end
		if (cmd.cap_sd) begin
			sd_q <= (|sqrt_root[RW-1:DW]) ? '1 : sqrt_root[DW-1:0];
		end
		if (cmd.cap_trim) begin
			trim_q <= t_w[TW-1] ? (~q_trim + 1'b1) : q_trim;
		end
		if (cmd.publish) begin
			out_q.trimmed_mean  <= trim_ok ? trim_q : '0;
			out_q.trimmed_valid <= trim_ok;
			out_q.std_dev       <= sd_q;
			out_q.sample_count  <= cnt_ext[NW-1:0];
			out_q.overflowed    <= dropped_q;
		end
	end

	assign status.div_done  = div_done;
	assign status.sqrt_done = sqrt_done;
	assign status.trim_ok   = trim_ok;
	assign result           = out_q;
endmodule

FILE: rtl/stmsd_ctrl.sv
// Sequencer: accumulate, then mean, deviation, variance, root, trimmed mean (if at least three samples), publish.
module stmsd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_last,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output stmsd_pkg::cmd_t    cmd,
	input  stmsd_pkg::status_t status
);
	stmsd_pkg::state_t state_q;
	stmsd_pkg::state_t state_d;
	logic              out_valid_q;
	logic              publish;

	assign publish = (state_q == stmsd_pkg::ST_PUB) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			stmsd_pkg::ST_ACC: begin
				if (in_valid && in_last) begin
					state_d = stmsd_pkg::ST_MEAN_GO;
				end
			end
			stmsd_pkg::ST_MEAN_GO:   state_d = stmsd_pkg::ST_MEAN_WAIT;
			stmsd_pkg::ST_MEAN_WAIT: begin
				if (status.div_done) begin
					state_d = stmsd_pkg::ST_MUL;
				end
			end
			stmsd_pkg::ST_MUL:    state_d = stmsd_pkg::ST_DEV;
			stmsd_pkg::ST_DEV:    state_d = stmsd_pkg::ST_VAR_GO;
			stmsd_pkg::ST_VAR_GO: state_d = stmsd_pkg::ST_VAR_WAIT;
			stmsd_pkg::ST_VAR_WAIT: begin
				if (status.div_done) begin
					state_d = stmsd_pkg::ST_SQRT_WAIT;
				end
			end
			stmsd_pkg::ST_SQRT_WAIT: begin
				if (status.sqrt_done) begin
					state_d = status.trim_ok ? stmsd_pkg::ST_TRIM_GO : stmsd_pkg::ST_PUB;
				end
			end
			stmsd_pkg::ST_TRIM_GO: state_d = stmsd_pkg::ST_TRIM_WAIT;
			stmsd_pkg::ST_TRIM_WAIT: begin
				if (status.div_done) begin
					state_d = stmsd_pkg::ST_PUB;
				end
			end
			stmsd_pkg::ST_PUB: begin
				if (publish) begin
					state_d = stmsd_pkg::ST_ACC;
				end
			end
			default: state_d = stmsd_pkg::ST_ACC;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.div_sel = stmsd_pkg::DIV_MEAN;
		in_ready = 1'b0;
		case (state_q)
			stmsd_pkg::ST_ACC: begin
				in_ready  = 1'b1;
				cmd.accum = in_valid;
			end
			stmsd_pkg::ST_MEAN_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = stmsd_pkg::DIV_MEAN;
			end
			stmsd_pkg::ST_MEAN_WAIT: cmd.cap_mean = status.div_done;
			stmsd_pkg::ST_MUL:       cmd.cap_prod = 1'b1;
			stmsd_pkg::ST_DEV:       cmd.cap_dev  = 1'b1;
			stmsd_pkg::ST_VAR_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = stmsd_pkg::DIV_VAR;
			end
			stmsd_pkg::ST_VAR_WAIT:  cmd.sqrt_start = status.div_done;
			stmsd_pkg::ST_SQRT_WAIT: cmd.cap_sd     = status.sqrt_done;
			stmsd_pkg::ST_TRIM_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = stmsd_pkg::DIV_TRIM;
			end
			stmsd_pkg::ST_TRIM_WAIT: cmd.cap_trim = status.div_done;
			stmsd_pkg::ST_PUB:       cmd.publish  = publish;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= stmsd_pkg::ST_ACC;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

FILE: sim/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import stmsd_pkg::*;

	// Capacity of one set and the knobs of the run.
	localparam int CAP          = DEFAULT_MAX_SAMPLES;
	localparam int RANDOM_ITEMS = 1600;
	localparam int MAX_GAP      = 14;
	localparam int SHOW_LIMIT   = 10;
	// Worst correct run: every request closes a set (divide and root) plus the
	// longest gap on both sides. The limit is several times that.
	localparam int CYCLE_LIMIT  = 1_500_000;
	// At the end, wait longer than closing a set takes, so a stray late result
	// is still caught.
	localparam int DVW          = 47 + $clog2(CAP);
	localparam int DRAIN_CYCLES = 3 * (DVW + 2) + (DVW + 1) / 2 + 4 + 50;

	// How the random sets are filled.
	typedef enum int {
		FILL_WIDE,
		FILL_NARROW,
		FILL_RAILS,
		FILL_FLAT,
		FILL_CLUSTER
	} fill_t;

	// One row of the directed table. Where "fixed" is set, "want" is the result
	// the closing request must produce; otherwise the predictor decides.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
		logic                       fixed;
		out_item_t                  want;
	} dir_row_t;

	localparam out_item_t NO_WANT = '0;
	localparam int DIR_ROWS = 23;
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		// lone sample at the negative rail: no trimmed mean, zero spread
		'{16'sh8000, 1'b1, 1'b1, out_item_t'{24'sd0, 1'b0, 24'd0, 5'd1, 1'b0}},
		// two samples, both rails: still too few for a trimmed mean
		'{16'sh7FFF, 1'b0, 1'b0, NO_WANT},
		'{16'sh8000, 1'b1, 1'b0, NO_WANT},
		// three equal samples at the positive rail: largest trimmed mean, no spread
		'{16'sh7FFF, 1'b0, 1'b0, NO_WANT},
		'{16'sh7FFF, 1'b0, 1'b0, NO_WANT},
		'{16'sh7FFF, 1'b1, 1'b1, out_item_t'{24'sd8388352, 1'b1, 24'd0, 5'd3, 1'b0}},
		// full set swinging rail to rail, then a closing request that is dropped
		'{16'sh8000, 1'b0, 1'b0, NO_WANT},
		'{16'sh7FFF, 1'b0, 1'b0, NO_WANT},
		'{16'sh8000, 1'b0, 1'b0, NO_WANT},
		'{16'sh7FFF, 1'b0, 1'b0, NO_WANT},
		'{16'sh8000, 1'b0, 1'b0, NO_WANT},
		'{16'sh7FFF, 1'b0, 1'b0, NO_WANT},
		'{16'sh8000, 1'b0, 1'b0, NO_WANT},
		'{16'sh7FFF, 1'b0, 1'b0, NO_WANT},
		'{16'sh8000, 1'b0, 1'b0, NO_WANT},
		'{16'sh7FFF, 1'b0, 1'b0, NO_WANT},
		'{16'sh8000, 1'b0, 1'b0, NO_WANT},
		'{16'sh7FFF, 1'b0, 1'b0, NO_WANT},
		'{16'sh8000, 1'b0, 1'b0, NO_WANT},
		'{16'sh7FFF, 1'b0, 1'b0, NO_WANT},
		'{16'sh8000, 1'b0, 1'b0, NO_WANT},
		'{16'sh7FFF, 1'b0, 1'b0, NO_WANT},
		'{16'sh0000, 1'b1, 1'b0, NO_WANT}
	};

	logic clk = 1'b0;
	logic arst_n;

	stmsd_stream_if #(.payload_t(in_item_t))  smp_if ();
	stmsd_stream_if #(.payload_t(out_item_t)) res_if ();

	sample_trimmed_mean_stddev_core #(
		.MAX_SAMPLES(CAP)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(smp_if),
		.results(res_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Running statistics of the open set, as the block should hold them.
	logic [CNT_OUT_W-1:0]       set_count;
	logic signed [20:0]         set_sum;
	logic [34:0]                set_sqsum;
	logic signed [SAMPLE_W-1:0] set_min;
	logic signed [SAMPLE_W-1:0] set_max;
	logic                       set_dropped;

	// Set statistics still owed by the block, oldest first.
	out_item_t pending_stats [$];

	int unsigned cycles       = 0;
	int          mismatches   = 0;
	int          samples_sent = 0;
	int          sets_closed  = 0;
	int          stats_seen   = 0;
	int          short_sets   = 0;
	int          spill_sets   = 0;

	task automatic clear_set();
		set_count   = '0;
		set_sum     = '0;
		set_sqsum   = '0;
		set_min     = '0;
		set_max     = '0;
		set_dropped = 1'b0;
	endtask

	// floor(sqrt(v)) by bisection; v stays below 2^52 here.
	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned lo, hi, mid;
		lo = 0;
		hi = 64'd1 << 26;
		while (hi - lo > 1) begin
			mid = (lo + hi) >> 1;
			if (mid * mid <= v)
				lo = mid;
			else
				hi = mid;
		end
		return lo;
	endfunction

	// Fold one accepted sample into the set. On the closing request, work out
	// the trimmed mean and the spread about the truncated integer mean.
	task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] x, input logic last,
	                             output bit closed, output out_item_t stats);
		longint          n, total, sq, m, dev, tmean;
		longint unsigned scaled, root;
		closed = 1'b0;
		stats  = '0;
		if (set_count < CAP) begin
			if (set_count == 0) begin
				set_min = x;
				set_max = x;
			end else begin
				if (x < set_min) set_min = x;
				if (x > set_max) set_max = x;
			end
			set_sum   = set_sum + x;
			set_sqsum = set_sqsum + 35'(longint'(x) * longint'(x));
			set_count = set_count + 1'b1;
		end else begin
			// set is full: the sample is lost but the set remembers it
			set_dropped = 1'b1;
		end
		if (!last)
			return;
		n     = longint'(set_count);
		total = longint'(set_sum);
		sq    = longint'({29'd0, set_sqsum});
		tmean = 0;
		root  = 0;
		if (n >= TRIM_MIN_COUNT)
			tmean = ((total - set_min - set_max) * (64'sd1 << FRAC_W)) / (n - 2);
		if (n >= 1) begin
			// exact sum of squared deviations about m, m truncated toward zero
			m   = total / n;
			dev = sq - 2 * m * total + n * m * m;
			if (dev < 0)
				dev = 0;
			scaled = (longint'(dev) << VAR_SHIFT) / n;
			root   = floor_root(scaled);
			if (root > 64'hFF_FFFF)
				root = 64'hFF_FFFF;
		end
		stats.trimmed_mean  = tmean[MEAN_W-1:0];
		stats.trimmed_valid = (n >= TRIM_MIN_COUNT);
		stats.std_dev       = root[SD_W-1:0];
		stats.sample_count  = set_count;
		stats.overflowed    = set_dropped;
		closed = 1'b1;
		clear_set();
	endtask

	// Offer one sample request after a random gap and hold it until taken.
	// A zero gap keeps valid high straight from the previous request.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic last,
	                           input logic fixed, input out_item_t want, input bit quiet);
		int        gap;
		bit        closed;
		out_item_t stats;
		gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap != 0) begin
			smp_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp_if.valid           <= 1'b1;
		smp_if.payload.sample  <= x;
		smp_if.payload.is_last <= last;
		@(posedge clk);
		while (!smp_if.ready) @(posedge clk);
		absorb_sample(x, last, closed, stats);
		samples_sent++;
		if (closed) begin
			sets_closed++;
			pending_stats.push_back(fixed ? want : stats);
		end
	endtask

	task automatic check_stats(input out_item_t got);
		out_item_t want;
		bit        bad;
		stats_seen++;
		if (pending_stats.size() == 0) begin
			mismatches++;
			if (mismatches <= SHOW_LIMIT)
				$display("[%0d] result request with nothing owed: mean %0d std %0d cnt %0d",
				         cycles, got.trimmed_mean, got.std_dev, got.sample_count);
			return;
		end
		want = pending_stats.pop_front();
		if (!want.trimmed_valid) short_sets++;
		if (want.overflowed)     spill_sets++;
		bad = (got.trimmed_mean  !== want.trimmed_mean)  ||
		      (got.trimmed_valid !== want.trimmed_valid) ||
		      (got.std_dev       !== want.std_dev)       ||
		      (got.sample_count  !== want.sample_count)  ||
		      (got.overflowed    !== want.overflowed);
		if (bad) begin
			mismatches++;
			if (mismatches <= SHOW_LIMIT) begin
				$display("[%0d] result %0d mismatch", cycles, stats_seen);
				$display("  want mean %0d ok %0b std %0d cnt %0d drop %0b",
				         want.trimmed_mean, want.trimmed_valid, want.std_dev,
				         want.sample_count, want.overflowed);
				$display("  got  mean %0d ok %0b std %0d cnt %0d drop %0b",
				         got.trimmed_mean, got.trimmed_valid, got.std_dev,
				         got.sample_count, got.overflowed);
			end
		end
	endtask

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still owed",
			         cycles, pending_stats.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result side. Either ready waits high for the next result, or it stays low
	// and the result is made to sit for a drawn number of cycles once it shows.
	// Quiet stretches keep ready high with no stalls at all.
	initial begin
		int stall;
		bit quiet;
		quiet = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0)
				quiet = !quiet;
			stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
			if (stall == 0) begin
				res_if.ready <= 1'b1;
				@(posedge clk);
				while (!res_if.valid) @(posedge clk);
			end else begin
				res_if.ready <= 1'b0;
				@(posedge clk);
				while (!res_if.valid) @(posedge clk);
				repeat (stall - 1) @(posedge clk);
				res_if.ready <= 1'b1;
				@(posedge clk);
				while (!res_if.valid) @(posedge clk);
			end
			check_stats(res_if.payload);
		end
	end

	// Sample side: reset, the directed table, then random sets until the
	// item budget is spent, then drain and report.
	initial begin
		int                         k, len, pick;
		fill_t                      fill;
		bit                         quiet;
		logic signed [SAMPLE_W-1:0] base, x;
		arst_n         <= 1'b0;
		smp_if.valid   <= 1'b0;
		smp_if.payload <= '0;
		res_if.ready   <= 1'b0;
		clear_set();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < DIR_ROWS; k++)
			send_sample(DIR_TABLE[k].sample, DIR_TABLE[k].last, DIR_TABLE[k].fixed,
			            DIR_TABLE[k].want, 1'b0);

		// Random sets: mostly 3..16 samples, some too short for a trimmed mean,
		// some long enough to spill past capacity.
		while (samples_sent < DIR_ROWS + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 19);
			if (pick < 3)
				len = $urandom_range(1, 2);
			else if (pick < 6)
				len = $urandom_range(CAP + 1, CAP + 4);
			else
				len = $urandom_range(TRIM_MIN_COUNT, CAP);
			fill  = fill_t'($urandom_range(0, 4));
			base  = SAMPLE_W'($urandom);
			quiet = ($urandom_range(0, 5) == 0);
			for (k = 0; k < len; k++) begin
				case (fill)
					FILL_WIDE:    x = SAMPLE_W'($urandom);
					FILL_NARROW:  x = SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
					FILL_RAILS:   x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
					FILL_FLAT:    x = base;
					default:      x = base + SAMPLE_W'(int'($urandom_range(0, 6)) - 3);
				endcase
				send_sample(x, k == len - 1, 1'b0, NO_WANT, quiet);
			end
		end
		smp_if.valid <= 1'b0;

		while (pending_stats.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d sample requests in %0d sets; checked %0d results", samples_sent,
		         sets_closed, stats_seen);
		$display("%0d sets too short to trim, %0d sets with dropped samples, %0d mismatches",
		         short_sets, spill_sets, mismatches);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
